>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: lbl");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition: lbl");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Constants and helpers shared by the integer to decimal text pipeline.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam logic [5:0] CODE_MINUS = 6'd45;
   localparam logic [5:0] CODE_ZERO  = 6'd48;
   localparam logic [5:0] CODE_NINE  = 6'd57;

   // shift-and-add-3 steps done in one pipeline stage
   localparam int STEP_BITS = 4;

   // decimal digits that cover any unsigned value of the given width
   function automatic int digit_count(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

endpackage

>>> rtl/sitda_sign_mag.sv
// ----------------------------------------------------------------------------
// sitda_sign_mag
// First pipeline stage: split the input word into sign and magnitude.
// ----------------------------------------------------------------------------
module sitda_sign_mag #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [VALUE_BITS-1:0] in_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_neg,
   output logic [VALUE_BITS-1:0] out_mag
);

   logic                  valid_ff, valid_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      neg_in   = in_value[VALUE_BITS-1];
      // most negative value maps to 2^(N-1), which still fits unsigned
      mag_in   = neg_in ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;

endmodule

>>> rtl/sitda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One pipeline stage of binary to BCD conversion: a few shift-and-add-3 steps.
// ----------------------------------------------------------------------------
module sitda_dabble_stage #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10,
   parameter int STEPS      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_neg,
   input  logic [DIGITS*4-1:0]   in_bcd,
   input  logic [VALUE_BITS-1:0] in_bin,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_neg,
   output logic [DIGITS*4-1:0]   out_bcd,
   output logic [VALUE_BITS-1:0] out_bin
);

   logic                  valid_ff, valid_in;
   logic                  neg_ff;
   logic [DIGITS*4-1:0]   bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      bcd_in   = in_bcd;
      bin_in   = in_bin;
      for (int s = 0; s < STEPS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_in[d*4 +: 4] >= 4'd5) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
            end
         end
         // shift the next magnitude bit into the digit string
         bcd_in = {bcd_in[DIGITS*4-2:0], bin_in[VALUE_BITS-1]};
         bin_in = {bin_in[VALUE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= in_neg;
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;

endmodule

>>> rtl/sitda_serializer.sv
// ----------------------------------------------------------------------------
// sitda_serializer
// Emits the minus sign and the significant BCD digits as ASCII, one a word.
// ----------------------------------------------------------------------------
module sitda_serializer #(
   parameter int DIGITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_neg,
   input  logic [DIGITS*4-1:0] in_bcd,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [5:0]          out_code,
   output logic                out_last
);

   localparam int IDX_W = $clog2(DIGITS);

   logic                busy_ff, busy_in;
   logic                minus_ff, minus_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DIGITS*4-1:0] bcd_ff;
   logic [IDX_W-1:0]    lead;
   logic                take, load;

   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i*4 +: 4] != 4'd0) begin
            lead = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (minus_ff) begin
         out_code = sitda_pkg::CODE_MINUS;
         out_last = 1'b0;
      end else begin
         out_code = sitda_pkg::CODE_ZERO + {2'b00, bcd_ff[idx_ff*4 +: 4]};
         out_last = (idx_ff == '0);
      end
   end

   assign out_valid = busy_ff;
   assign take      = busy_ff && out_ready;
   assign in_ready  = !busy_ff || (out_ready && out_last);
   assign load      = in_valid && in_ready;

   always_comb begin
      busy_in  = busy_ff;
      minus_in = minus_ff;
      idx_in   = idx_ff;
      if (load) begin
         busy_in  = 1'b1;
         minus_in = in_neg;
         idx_in   = lead;
      end else if (take) begin
         if (minus_ff) begin
            minus_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         minus_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         minus_ff <= minus_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff <= in_bcd;
      end
   end

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, streaming in and out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one signed VALUE_BITS integer per word in req_tdata.
//   rsp_ channel gives its decimal text, one ASCII code per word, most
//   significant character first; a negative value is led by '-', and
//   rsp_tlast marks the final digit of each number.
//   Pipeline: one sign/magnitude stage, ceil(VALUE_BITS/4) BCD stages
//   (8 at 32 bits) and the output register in the serializer.
//   Throughput: one character per cycle while rsp_tready is high; a
//   number takes one output word per character, 1 to 11 characters at
//   32 bits, and the serializer takes the next number in the cycle its
//   final character leaves.
//   The BCD pipeline accepts a word every cycle while it is not backed
//   up, and buffers numbers while the serializer is busy.
//   Reset clears all valid bits; no text is in flight afterwards.
//   A stall on rsp_tready holds the current character and backs up the
//   pipeline stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,   // value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // char_code, zero pad
   output logic                              rsp_tlast    // last_char
);

   localparam int DIGITS     = sitda_pkg::digit_count(VALUE_BITS);
   localparam int NUM_STAGES = (VALUE_BITS + sitda_pkg::STEP_BITS - 1) / sitda_pkg::STEP_BITS;

   logic                  pipe_valid [0:NUM_STAGES];
   logic                  pipe_ready [0:NUM_STAGES];
   logic                  pipe_neg   [0:NUM_STAGES];
   logic [DIGITS*4-1:0]   pipe_bcd   [0:NUM_STAGES];
   logic [VALUE_BITS-1:0] pipe_bin   [0:NUM_STAGES];
   logic [5:0]            char_code;

   sitda_sign_mag #(
      .VALUE_BITS(VALUE_BITS)
   ) u_sign_mag (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_value (req_tdata[VALUE_BITS-1:0]),
      .out_valid(pipe_valid[0]),
      .out_ready(pipe_ready[0]),
      .out_neg  (pipe_neg[0]),
      .out_mag  (pipe_bin[0])
   );

   assign pipe_bcd[0] = '0;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
      localparam int REMAIN = VALUE_BITS - g * sitda_pkg::STEP_BITS;
      localparam int STEPS  = (REMAIN < sitda_pkg::STEP_BITS) ? REMAIN : sitda_pkg::STEP_BITS;

      sitda_dabble_stage #(
         .VALUE_BITS(VALUE_BITS),
         .DIGITS    (DIGITS),
         .STEPS     (STEPS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (pipe_valid[g]),
         .in_ready (pipe_ready[g]),
         .in_neg   (pipe_neg[g]),
         .in_bcd   (pipe_bcd[g]),
         .in_bin   (pipe_bin[g]),
         .out_valid(pipe_valid[g+1]),
         .out_ready(pipe_ready[g+1]),
         .out_neg  (pipe_neg[g+1]),
         .out_bcd  (pipe_bcd[g+1]),
         .out_bin  (pipe_bin[g+1])
      );
   end

   sitda_serializer #(
      .DIGITS(DIGITS)
   ) u_serializer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pipe_valid[NUM_STAGES]),
      .in_ready (pipe_ready[NUM_STAGES]),
      .in_neg   (pipe_neg[NUM_STAGES]),
      .in_bcd   (pipe_bcd[NUM_STAGES]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_code (char_code),
      .out_last (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, char_code};

   // a number's text never breaks off before its final character
   `ASSERT_CLK(a_run_unbroken, clock, reset,
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)

   // only the minus sign and the ten digit codes leave
   `ASSERT_CLK(a_code_legal, clock, reset,
      rsp_tvalid |-> (char_code == sitda_pkg::CODE_MINUS ||
                      (char_code >= sitda_pkg::CODE_ZERO &&
                       char_code <= sitda_pkg::CODE_NINE)))

   // a minus sign is followed by a digit, never by another sign
   `ASSERT_CLK(a_digit_after_minus, clock, reset,
      (rsp_tvalid && rsp_tready && char_code == sitda_pkg::CODE_MINUS) |=>
         (rsp_tvalid && char_code != sitda_pkg::CODE_MINUS))

   // the minus sign never closes a number
   `ASSERT_NEVER(a_minus_not_last, clock, reset,
      rsp_tvalid && rsp_tlast && char_code == sitda_pkg::CODE_MINUS)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_int_to_decimal_ascii: drives signed 32-bit
// words with random gaps, predicts each decimal text and checks every
// character, pad bit and tlast flag under random and long output stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VALUE_BITS  = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 12;
   localparam int DRAIN_WAIT  = 24;

   typedef struct packed {
      logic [5:0] code;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // char_code, zero pad
   logic        rsp_tlast;         // last_char

   text_char_type pending_text [$];
   int          error_count    = 0;
   int          cycle_count    = 0;
   int          chars_checked  = 0;
   int          texts_checked  = 0;
   int          words_sent     = 0;
   int          negatives_sent = 0;
   bit          no_idle        = 1'b0;
   int          hold_request   = 0;
   int          hold_left      = 0;

   int unsigned pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                               10000000, 100000000, 1000000000};

   signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, pending_text.size());
         $display("testbench failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Expand one word into the characters of its decimal text.
   function automatic void predict_text(input logic [31:0] value);
      logic          negative;
      logic [32:0]   magnitude;
      logic [3:0]    digits [$];
      text_char_type ch;
      negative  = value[31];
      // widen by one bit so the most negative value keeps its magnitude
      magnitude = negative ? -{value[31], value} : {1'b0, value};
      do begin
         digits.push_front(4'(magnitude % 33'd10));
         magnitude = magnitude / 33'd10;
      end while (magnitude != 0);
      if (negative) begin
         ch.code = sitda_pkg::CODE_MINUS;
         ch.last = 1'b0;
         pending_text.push_back(ch);
      end
      foreach (digits[i]) begin
         ch.code = sitda_pkg::CODE_ZERO + 6'(digits[i]);
         ch.last = (i == digits.size() - 1);
         pending_text.push_back(ch);
      end
   endfunction

   // Offer one word; return at the edge where it is taken.
   task automatic send_word(input logic [31:0] value);
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_text(value);
      words_sent++;
      if (value[31]) negatives_sent++;
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected word tdata=%0d tlast=%0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = pending_text.pop_front();
            if (rsp_tdata[5:0] !== want.code)
               report_mismatch($sformatf("char_code %0d, want %0d",
                                         rsp_tdata[5:0], want.code));
            if (rsp_tdata[7:6] !== 2'b00)
               report_mismatch($sformatf("pad bits %b, want 00", rsp_tdata[7:6]));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_char %0b, want %0b",
                                         rsp_tlast, want.last));
            chars_checked++;
            if (want.last) texts_checked++;
         end
      end
   end

   function automatic logic [31:0] random_value();
      int unsigned k;
      int unsigned mag;
      k = $urandom_range(9);
      case ($urandom_range(3))
         0: return $urandom();
         1: mag = pow10[k] + $urandom_range(1) - (k == 0 ? 0 : 1);
         default: begin
            if (k == 9) mag = $urandom_range(32'd2147483647, pow10[9]);
            else        mag = $urandom_range(pow10[k + 1] - 1, pow10[k]);
         end
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   task automatic test_directed();
      logic [31:0] corner [$];
      corner = '{32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                 -32'd999, 32'd123456789, 32'd999999999, 32'd1000000000,
                 -32'd1000000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
                 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFF6, 32'd4294967295 - 32'd8};
      foreach (corner[i]) send_word(corner[i]);
   endtask

   // Hold the output long enough that the pipeline fills and req_tready drops.
   task automatic test_output_stall();
      hold_request = 300;
      repeat (40) send_word(random_value());
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      repeat (50) send_word(random_value());
      no_idle = 1'b0;
   endtask

   task automatic test_random_values();
      repeat (250) send_word(random_value());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_output_stall();
      test_full_rate();
      test_random_values();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d numbers (%0d negative), %0d texts and %0d characters",
               words_sent, negatives_sent, texts_checked, chars_checked);
      $display("corner values, a long output stall, full-rate and random traffic");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_sign_mag.sv
rtl/sitda_dabble_stage.sv
rtl/sitda_serializer.sv
rtl/signed_int_to_decimal_ascii.sv
sim/testbench.sv
